// File: rtl/core/mcod_pkg.sv
// ---------------------------------------------------------------------------
// mcod_pkg: shared types and constants of the motor channel drive core
// Item layouts of both streams, register indexes and filter weights.
// ---------------------------------------------------------------------------
package mcod_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_SPEED_LIMIT     = 2'd0;
	localparam logic [1:0] REG_OVERSPEED_THR   = 2'd1;
	localparam logic [1:0] REG_REVERSE_POL     = 2'd2;

	localparam logic [13:0] SPEED_LIMIT_RST    = 14'd8000;
	localparam logic [15:0] OVERSPEED_THR_RST  = 16'd4000;

	// low-pass weights, q8: 0.7 and 0.3
	localparam logic signed [8:0] W_OLD = 9'sd179;
	localparam logic signed [8:0] W_NEW = 9'sd77;

	// consecutive overspeed ticks that cut the drive
	localparam logic [3:0] RUN_LIMIT = 4'd10;

	// input item, last field in the lowest bits
	typedef struct packed {
		logic signed [14:0] commanded_speed;
		logic               encoder_direction;
		logic        [15:0] encoder_count;
	} in_item_t;

	// result item, last field in the lowest bits, padded to whole bytes
	typedef struct packed {
		logic        [2:0]  pad;
		logic signed [24:0] filtered_speed;
		logic               overspeed_fault;
		logic signed [14:0] applied_speed;
		logic        [13:0] reverse_duty;
		logic        [13:0] forward_duty;
	} out_item_t;

	typedef struct packed {
		logic [13:0] speed_limit;
		logic [15:0] overspeed_threshold;
		logic        reverse_polarity;
	} cfg_t;

endpackage

// File: rtl/core/mcod_datapath.sv
// ---------------------------------------------------------------------------
// mcod_datapath: filter, overspeed run and pwm split for one item
// Combinational step from the registered item and current state to the
// next state and the result item.
// ---------------------------------------------------------------------------
module mcod_datapath import mcod_pkg::*; (
	input  in_item_t           item,
	input  cfg_t               cfg,
	input  logic signed [24:0] est_q,
	input  logic        [3:0]  run_q,
	output logic signed [24:0] est_d,
	output logic        [3:0]  run_d,
	output out_item_t          result
);

	logic signed [16:0] sample;
	logic signed [24:0] sample_q8;
	logic signed [33:0] acc;
	logic        [24:0] mag;
	logic               over;
	logic               fault;
	logic signed [15:0] cmd;
	logic signed [15:0] lim;
	logic signed [15:0] clamped;

	always_comb begin
		if (item.encoder_direction == cfg.reverse_polarity) begin
			sample = $signed({1'b0, item.encoder_count});
		end else begin
			sample = -$signed({1'b0, item.encoder_count});
		end
	end

	assign sample_q8 = $signed({sample, 8'h00});
	assign acc       = W_OLD * est_q + W_NEW * sample_q8;
	// floor division by 256; weights sum to 256 so the result stays in range
	assign est_d     = acc[32:8];

	assign mag  = est_d[24] ? 25'(-est_d) : 25'(est_d);
	assign over = mag >= {1'b0, cfg.overspeed_threshold, 8'h00};

	always_comb begin
		if (!over) begin
			run_d = '0;
		end else if (run_q < RUN_LIMIT) begin
			run_d = run_q + 4'd1;
		end else begin
			run_d = run_q;
		end
	end

	assign fault = run_d >= RUN_LIMIT;

	assign cmd = 16'(item.commanded_speed);
	assign lim = $signed({2'b00, cfg.speed_limit});

	always_comb begin
		if (cmd >= lim) begin
			clamped = lim;
		end else if (cmd <= -lim) begin
			clamped = -lim;
		end else begin
			clamped = cmd;
		end
	end

	always_comb begin
		result                 = '0;
		result.filtered_speed  = est_d;
		result.overspeed_fault = fault;
		if (!fault) begin
			result.applied_speed = clamped[14:0];
			if (clamped[15]) begin
				result.reverse_duty = 14'(-clamped);
			end else begin
				result.forward_duty = clamped[13:0];
			end
		end
	end

endmodule

// File: rtl/core/motor_channel_overspeed_drive_core.sv
// ---------------------------------------------------------------------------
// motor_channel_overspeed_drive_core: one h-bridge motor channel
// Encoder speed low-pass filter, overspeed cutoff and pwm duty split.
// ---------------------------------------------------------------------------
//  channel   | signals                          | item
//  ----------+----------------------------------+------------------------------
//  s_axis    | tvalid tready tdata[31:0]        | encoder sample and command
//  m_axis    | tvalid tready tdata[71:0]        | duties, speed, fault, filter
//  cfg       | cfg_we cfg_index[1:0] cfg_data   | register write, no read-back
//
//  one item per cycle while m_axis does not stall; an accepted item passes
//  the input register, then the result register holding the filter/clamp step,
//  before it shows on m_axis; filter state and overspeed run update when an
//  item moves into the result register; a stalled result holds while one more
//  item waits in the input register, so s_axis_tready drops only when both are
//  full and m_axis stalls; arst_n clears filter state, run count and valids
//  and sets config to its reset values; item and result data regs are not reset
// ---------------------------------------------------------------------------
module motor_channel_overspeed_drive_core import mcod_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// encoder_count[15:0], encoder_direction[16], commanded_speed[31:17]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// forward_duty[13:0], reverse_duty[27:14], applied_speed[42:28],
	// overspeed_fault[43], filtered_speed[68:44], zero pad[71:69]
	output logic [71:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t               cfg_q;
	in_item_t           item_s1;
	logic               valid_s1;
	out_item_t          result_s2;
	logic               valid_s2;
	logic signed [24:0] est_q;
	logic        [3:0]  run_q;
	logic signed [24:0] est_d;
	logic        [3:0]  run_d;
	out_item_t          result_d;
	logic               adv_s2;
	logic               take_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.speed_limit         <= SPEED_LIMIT_RST;
			cfg_q.overspeed_threshold <= OVERSPEED_THR_RST;
			cfg_q.reverse_polarity    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_LIMIT:   cfg_q.speed_limit         <= cfg_data[13:0];
				REG_OVERSPEED_THR: cfg_q.overspeed_threshold <= cfg_data;
				REG_REVERSE_POL:   cfg_q.reverse_polarity    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv_s2        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= in_item_t'(s_axis_tdata);
		end
	end

	mcod_datapath u_datapath (
		.item   (item_s1),
		.cfg    (cfg_q),
		.est_q  (est_q),
		.run_q  (run_q),
		.est_d  (est_d),
		.run_d  (run_d),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q    <= '0;
			run_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s2) begin
				est_q    <= est_d;
				run_q    <= run_d;
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2 <= result_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

endmodule
